[rtl/core/lcsr_pkg.sv]
package lcsr_pkg;

	// fixed field widths of the result beat
	localparam int MATCH_W = 7;
	localparam int RATIO_W = 17;
	// quotient steps run from RATIO_W-1 down to zero
	localparam int STEP_W  = 5;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_START,
		ST_DIV
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

[rtl/core/lcsr_div.sv]
module lcsr_div #(
	parameter int LW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [LW-1:0]                 num,
	input  logic [LW-1:0]                 den,
	output logic                          done,
	output logic [lcsr_pkg::RATIO_W-1:0]  quot
);
	import lcsr_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [LW-1:0]       rem_q;
	logic                nbit_q;
	logic [RATIO_W-1:0]  quot_q;
	logic [LW:0]         rem_sh;
	logic [LW:0]         rem_nx;
	logic                fits;

	// restoring step, remainder stays below the divisor
	always_comb begin
		rem_sh = {rem_q, nbit_q};
		fits   = rem_sh >= {1'b0, den};
		rem_nx = fits ? (rem_sh - {1'b0, den}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEP_W'(RATIO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// dividend is num shifted up by the fraction width
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num >> 1;
			nbit_q <= num[0];
		end else if (busy_q) begin
			rem_q  <= rem_nx[LW-1:0];
			nbit_q <= 1'b0;
			quot_q <= {quot_q[RATIO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && den != '0) |-> rem_q < den)
		else $error("divider remainder reached the divisor");

endmodule

[rtl/core/lcsr_datapath.sv]
module lcsr_datapath #(
	parameter int MAX_LEN = 64,
	parameter int LW      = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcsr_pkg::cmd_t                cmd,
	input  logic                          op,
	input  logic [7:0]                    ch,
	input  logic                          char_valid,
	input  logic [lcsr_pkg::RATIO_W-1:0]  quot,
	output logic [LW-1:0]                 num,
	output logic [LW-1:0]                 den,
	output logic [lcsr_pkg::MATCH_W-1:0]  match_length,
	output logic [lcsr_pkg::RATIO_W-1:0]  ratio,
	output logic                          truncated
);
	import lcsr_pkg::*;

	logic [7:0]          ref_q   [MAX_LEN];
	logic [LW-1:0]       sfx_q   [MAX_LEN];
	logic [LW-1:0]       diag    [MAX_LEN];
	logic [MAX_LEN-1:0]  active;
	logic [MAX_LEN-1:0]  hit;
	logic [LW-1:0]       first_len_q;
	logic [LW-1:0]       second_len_q;
	logic [LW-1:0]       best_q;
	logic                ovf_q;
	logic                wr_first;
	logic                step_second;
	logic                drop;
	logic [LW-1:0]       longer;
	logic [MATCH_W-1:0]  match_len_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic                trunc_q;

	always_comb begin
		wr_first    = cmd.accept && !op && char_valid && (first_len_q < LW'(MAX_LEN));
		step_second = cmd.accept && op && char_valid && (second_len_q < LW'(MAX_LEN));
		drop        = cmd.accept && char_valid &&
		              (op ? (second_len_q == LW'(MAX_LEN)) : (first_len_q == LW'(MAX_LEN)));
		longer      = (first_len_q > second_len_q) ? first_len_q : second_len_q;
	end

	// one cell per reference position, all updated in the same cycle
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign diag[i] = '0;
		end else begin : g_rest
			assign diag[i] = sfx_q[i-1];
		end

		assign active[i] = LW'(i) < first_len_q;
		assign hit[i]    = step_second && active[i] && (ref_q[i] == ch) && (diag[i] == best_q);

		always_ff @(posedge clk) begin
			if (wr_first && first_len_q == LW'(i)) begin
				ref_q[i] <= ch;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sfx_q[i] <= '0;
			end else if (cmd.load_out) begin
				sfx_q[i] <= '0;
			end else if (wr_first && first_len_q == LW'(i)) begin
				sfx_q[i] <= '0;
			end else if (step_second && active[i]) begin
				sfx_q[i] <= (ref_q[i] == ch) ? (diag[i] + 1'b1) : '0;
			end
		end
	end

	// a new cell value is at most one above the running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			best_q       <= '0;
			ovf_q        <= 1'b0;
		end else if (cmd.load_out) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			best_q       <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (wr_first) begin
				first_len_q <= first_len_q + 1'b1;
			end
			if (step_second) begin
				second_len_q <= second_len_q + 1'b1;
			end
			if (|hit) begin
				best_q <= best_q + 1'b1;
			end
			if (drop) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			match_len_q <= MATCH_W'(best_q);
			ratio_q     <= (longer == '0) ? '0 : quot;
			trunc_q     <= ovf_q;
		end
	end

	assign num          = best_q;
	assign den          = longer;
	assign match_length = match_len_q;
	assign ratio        = ratio_q;
	assign truncated    = trunc_q;

	a_best_first: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= first_len_q)
		else $error("best length beyond first string length");

	a_best_second: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= second_len_q)
		else $error("best length beyond second string length");

	a_best_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load_out |=> (best_q == $past(best_q) || best_q == $past(best_q) + 1'b1))
		else $error("best length jumped");

endmodule

[rtl/core/lcsr_ctrl.sv]
module lcsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               op,
	input  logic               last,
	input  logic               out_ready,
	input  lcsr_pkg::status_t  status,
	output logic               in_ready,
	output logic               out_valid,
	output lcsr_pkg::cmd_t     cmd
);
	import lcsr_pkg::*;

	ctrl_state_t  state_q;
	ctrl_state_t  state_nx;
	logic         out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.start_div = 1'b0;
		cmd.load_out  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && op && last) begin
					state_nx = ST_START;
				end
			end
			ST_START: begin
				cmd.start_div = 1'b1;
				state_nx      = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done && !out_full_q) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_LOAD;
				end
			end
			default: begin
				state_nx = ST_LOAD;
			end
		endcase
	end

	// output register, freed when its beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	assign out_valid = out_full_q;

endmodule

[rtl/core/longest_common_substring_ratio.sv]
// the result follows the second string's end beat via ST_START, ST_DIV and the output register
// one character beat per cycle in ST_LOAD; in_ready is low until the result is loaded
// the divider is a 17-step restoring divider that forms the Q1.16 ratio, one quotient bit a cycle
// a new pair may stream in while the previous result waits in the output register
// reset: arst_n asynchronous active low, clears lengths, best length, flags and the suffix row
module longest_common_substring_ratio #(
	parameter int MAX_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [7:0]                    ch,
	input  logic                          char_valid,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lcsr_pkg::MATCH_W-1:0]  match_length,
	output logic [lcsr_pkg::RATIO_W-1:0]  ratio,
	output logic                          truncated
);
	import lcsr_pkg::*;

	// length counters hold zero up to MAX_LEN inclusive
	localparam int LW = $clog2(MAX_LEN + 1);

	cmd_t                cmd;
	status_t             status;
	logic [LW-1:0]       num;
	logic [LW-1:0]       den;
	logic [RATIO_W-1:0]  quot;

	// sequencer: takes character beats, then runs the divider and loads the result
	lcsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.last      (last),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// reference store, systolic suffix row, counters and output register
	lcsr_datapath #(
		.MAX_LEN (MAX_LEN),
		.LW      (LW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.ch           (ch),
		.char_valid   (char_valid),
		.quot         (quot),
		.num          (num),
		.den          (den),
		.match_length (match_length),
		.ratio        (ratio),
		.truncated    (truncated)
	);

	// best length times 2^16 over the longer string length
	lcsr_div #(
		.LW (LW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.num    (num),
		.den    (den),
		.done   (status.div_done),
		.quot   (quot)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_LEN        = 64;
	// no beat on either channel for this long means the block is stuck
	localparam int WATCHDOG_LIMIT = 2000;
	// drain time after the last result, divider tail plus margin
	localparam int TAIL_CYCLES    = 40;
	// longest idle run the sender inserts before one beat
	localparam int MAX_GAP        = 30;

	localparam logic OP_FIRST  = 1'b0;
	localparam logic OP_SECOND = 1'b1;

	typedef logic [7:0] char_q_t [$];

	typedef struct packed {
		logic [lcsr_pkg::MATCH_W-1:0] match_length;
		logic [lcsr_pkg::RATIO_W-1:0] ratio;
		logic                         truncated;
	} lcs_result_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic                         op         = 1'b0;
	logic [7:0]                   ch         = 8'h00;
	logic                         char_valid = 1'b0;
	logic                         last       = 1'b0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [lcsr_pkg::MATCH_W-1:0] match_length;
	logic [lcsr_pkg::RATIO_W-1:0] ratio;
	logic                         truncated;

	// idling mix, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int error_count  = 0;
	int beats_sent   = 0;
	int quiet_cycles = 0;

	// results still owed by the block, oldest first
	lcs_result_t expected_scores [$];

	// mirror of the block state
	logic [7:0]  ref_str    [MAX_LEN];
	logic [6:0]  suffix_len [MAX_LEN];
	int unsigned len_first;
	int unsigned len_second;
	int unsigned best_run;
	logic        overflow_seen;

	longest_common_substring_ratio #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.ch          (ch),
		.char_valid  (char_valid),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match_length(match_length),
		.ratio       (ratio),
		.truncated   (truncated)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction of the longest common run and its ratio
	// ------------------------------------------------------------------

	function automatic void clear_pair();
		int i;
		for (i = 0; i < MAX_LEN; i++) begin
			suffix_len[i] = '0;
			ref_str[i]    = '0;
		end
		len_first     = 0;
		len_second    = 0;
		best_run      = 0;
		overflow_seen = 1'b0;
	endfunction

	// fold one accepted input beat into the mirror, queue a result on end of pair
	function automatic void lcs_absorb_beat(logic b_op, logic [7:0] b_ch, logic b_cv,
		logic b_last);
		int          i;
		int unsigned diag;
		int unsigned longer;
		lcs_result_t res;
		if (b_op == OP_FIRST) begin
			if (b_cv) begin
				if (len_first < MAX_LEN) begin
					ref_str[len_first]    = b_ch;
					suffix_len[len_first] = '0;
					len_first++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
			return;
		end
		if (b_cv) begin
			if (len_second < MAX_LEN) begin
				// walk down so each cell still sees the old diagonal value
				for (i = int'(len_first) - 1; i >= 0; i--) begin
					if (ref_str[i] == b_ch) begin
						diag = (i > 0) ? 32'(suffix_len[i-1]) : 0;
						suffix_len[i] = 7'(diag + 1);
						if (diag + 1 > best_run)
							best_run = diag + 1;
					end else begin
						suffix_len[i] = '0;
					end
				end
				len_second++;
			end else begin
				overflow_seen = 1'b1;
			end
		end
		if (!b_last)
			return;
		longer = (len_first > len_second) ? len_first : len_second;
		res.match_length = lcsr_pkg::MATCH_W'(best_run);
		res.ratio        = (longer != 0) ? lcsr_pkg::RATIO_W'((best_run << 16) / longer) : '0;
		res.truncated    = overflow_seen;
		expected_scores.push_back(res);
		clear_pair();
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_result();
		lcs_result_t want;
		if (expected_scores.size() == 0) begin
			report_mismatch($sformatf("result beat with nothing owed (len %0d ratio %0d)",
				match_length, ratio));
			return;
		end
		want = expected_scores.pop_front();
		if (match_length !== want.match_length)
			report_mismatch($sformatf("match_length %0d, wanted %0d", match_length,
				want.match_length));
		if (ratio !== want.ratio)
			report_mismatch($sformatf("ratio %0d, wanted %0d", ratio, want.ratio));
		if (truncated !== want.truncated)
			report_mismatch($sformatf("truncated %0b, wanted %0b", truncated,
				want.truncated));
	endtask

	// both channels sampled at the edge, before any drive from this edge lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				lcs_absorb_beat(op, ch, char_valid, last);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog, looked at between edges
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// one input beat, with a random idle run in front of it
	task automatic send_beat(input logic b_op, input logic [7:0] b_ch, input logic b_cv,
		input logic b_last);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= b_op;
		ch         <= b_ch;
		char_valid <= b_cv;
		last       <= b_last;
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent++;
	endtask

	// one string; an empty one or a marker-ended one closes with a bare end beat
	task automatic send_str(input logic s_op, input char_q_t s, input bit marker,
		input bit noisy);
		int k;
		for (k = 0; k < s.size(); k++) begin
			if (noisy && $urandom_range(5) == 0) begin
				// stray beats: late reference characters or ignored non-characters
				if (s_op == OP_SECOND && $urandom_range(1))
					send_beat(OP_FIRST, 8'($urandom), 1'b1, 1'($urandom));
				else
					send_beat(s_op, 8'($urandom), 1'b0,
						(s_op == OP_FIRST) ? 1'($urandom) : 1'b0);
			end
			send_beat(s_op, s[k], 1'b1, (k == s.size() - 1) && !marker);
		end
		if (marker || s.size() == 0)
			send_beat(s_op, 8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic send_pair(input char_q_t a, input char_q_t b, input bit marker_a,
		input bit marker_b, input bit noisy);
		send_str(OP_FIRST, a, marker_a, noisy);
		send_str(OP_SECOND, b, marker_b, noisy);
	endtask

	function automatic int pick_len();
		case ($urandom_range(19))
			0: begin
				return $urandom_range(60, 70);
			end
			1: begin
				return $urandom_range(13, 59);
			end
			default: begin
				return $urandom_range(0, 12);
			end
		endcase
	endfunction

	function automatic int pick_alphabet();
		case ($urandom_range(4))
			0: begin
				return 1;
			end
			1: begin
				return 2;
			end
			2: begin
				return 4;
			end
			3: begin
				return 16;
			end
			default: begin
				return 256;
			end
		endcase
	endfunction

	// both empty, one empty each way
	task automatic test_empty_strings();
		char_q_t none;
		char_q_t a;
		a = '{8'h00, 8'hFF};
		send_pair(none, none, 1'b0, 1'b0, 1'b0);
		send_pair(a, none, 1'b0, 1'b0, 1'b0);
		send_pair(none, a, 1'b0, 1'b0, 1'b0);
	endtask

	// character extremes, a partial match and a full match
	task automatic test_char_extremes();
		char_q_t a;
		char_q_t b;
		a = '{8'h00, 8'hFF, 8'h00};
		b = '{8'hFF, 8'h00, 8'hFF};
		send_pair(a, b, 1'b0, 1'b0, 1'b0);
		send_pair(b, b, 1'b0, 1'b0, 1'b0);
	endtask

	// strings closed by a bare end beat rather than on their last character
	task automatic test_end_markers();
		char_q_t a;
		char_q_t b;
		a = '{8'h41, 8'h42};
		b = '{8'h42};
		send_pair(a, b, 1'b1, 1'b1, 1'b0);
	endtask

	// reference grows after the second string has begun
	task automatic test_late_reference();
		send_beat(OP_FIRST, 8'h78, 1'b1, 1'b1);
		send_beat(OP_SECOND, 8'h79, 1'b1, 1'b0);
		send_beat(OP_FIRST, 8'h79, 1'b1, 1'b0);
		send_beat(OP_FIRST, 8'h5A, 1'b0, 1'b1);
		send_beat(OP_SECOND, 8'h79, 1'b1, 1'b1);
	endtask

	// full-length match, and overflow of each string
	task automatic test_length_limits();
		char_q_t a;
		char_q_t b;
		char_q_t none;
		logic [7:0] base;
		int k;
		base = 8'($urandom);
		for (k = 0; k < MAX_LEN; k++)
			a.push_back(base);
		send_pair(a, a, 1'b0, 1'b0, 1'b0);
		a.delete();
		for (k = 0; k < MAX_LEN + 2; k++)
			a.push_back(8'(base + $urandom_range(1)));
		for (k = 0; k < MAX_LEN + 3; k++)
			b.push_back((k < MAX_LEN) ? a[k] : 8'($urandom));
		send_pair(a, b, 1'b0, 1'b1, 1'b0);
		a.delete();
		for (k = 0; k < MAX_LEN; k++)
			a.push_back(8'($urandom));
		send_pair(a, none, 1'b0, 1'b0, 1'b0);
	endtask

	// mostly well-formed pairs, often sharing a spliced run, some with noise
	task automatic test_random_pairs(input int budget);
		char_q_t a;
		char_q_t b;
		logic [7:0] base;
		int alpha;
		int k;
		int s;
		int n;
		int pos;
		int start;
		start = beats_sent;
		while (beats_sent - start < budget) begin
			a.delete();
			b.delete();
			alpha = pick_alphabet();
			base  = 8'($urandom);
			n     = pick_len();
			for (k = 0; k < n; k++)
				a.push_back(8'(base + $urandom_range(alpha - 1)));
			n = pick_len();
			for (k = 0; k < n; k++)
				b.push_back(8'(base + $urandom_range(alpha - 1)));
			if (a.size() > 0 && $urandom_range(1)) begin
				// copy a run of the first string into the second
				s   = $urandom_range(a.size() - 1);
				n   = $urandom_range(1, a.size() - s);
				pos = $urandom_range(b.size());
				for (k = 0; k < n; k++)
					b.insert(pos + k, a[s + k]);
			end
			send_pair(a, b, $urandom_range(3) == 0, $urandom_range(3) == 0,
				$urandom_range(9) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		clear_pair();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalled
		send_idle_pct  = 8;
		recv_stall_pct = 69;
		test_empty_strings();
		test_char_extremes();
		test_end_markers();
		test_late_reference();
		test_length_limits();
		test_random_pairs(500);

		// sender mostly idle, receiver mostly ready
		send_idle_pct  = 69;
		recv_stall_pct = 8;
		test_random_pairs(500);

		// full rate both sides
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_pairs(500);

		in_valid <= 1'b0;
		while (expected_scores.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_scores.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
